// ----- rtl/cbs_pkg.sv -----
`default_nettype none

package cbs_pkg;

  localparam int CBS_QUEUE_DEPTH = 16;
  localparam int CBS_WORK_W      = 16;
  localparam int CBS_BUDGET_W    = 16;
  localparam int CBS_TIME_W      = 32;
  localparam int CBS_PERIOD_W    = 24;
  localparam int CBS_BW_W        = 17;
  localparam int CBS_CFG_IDX_W   = 2;
  localparam int CBS_CFG_DATA_W  = 24;

  typedef enum logic [CBS_CFG_IDX_W-1:0] {
    CFG_FULL_BUDGET   = 2'd0,
    CFG_PERIOD_LENGTH = 2'd1,
    CFG_BANDWIDTH_Q16 = 2'd2
  } cbs_cfg_idx_t;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [CBS_TIME_W-1:0] arrival_time;
    logic [CBS_WORK_W-1:0] work_amount;
  } cbs_in_t;

  typedef struct packed {
    logic                    job_finished;
    logic                    job_dropped;
    logic                    idle_tick;
    logic                    busy_res;
    logic [CBS_BUDGET_W-1:0] budget_now;
    logic [CBS_TIME_W-1:0]   deadline_now;
    logic [CBS_TIME_W-1:0]   job_deadline_now;
    logic [CBS_WORK_W-1:0]   work_left;
  } cbs_out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cbs_qctl_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } cbs_qstat_t;

endpackage

`default_nettype wire

// ----- rtl/cbs_queue.sv -----
`default_nettype none

module cbs_queue #(
  parameter int DEPTH = cbs_pkg::CBS_QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire cbs_pkg::cbs_qctl_t              ctl,
  input  wire logic [cbs_pkg::CBS_WORK_W-1:0]  wdata,
  output cbs_pkg::cbs_qstat_t                  stat,
  output logic      [cbs_pkg::CBS_WORK_W-1:0]  head_data
);
  import cbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CBS_WORK_W-1:0] mem [DEPTH];
  logic [AW-1:0]         head_r;
  logic [AW-1:0]         head_nxt;
  logic [AW-1:0]         head_inc;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [AW:0]           tail_sum;
  logic [AW-1:0]         tail;
  logic [CBS_WORK_W-1:0] rd_data_r;

  always_comb begin
    head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    head_nxt  = ctl.pop ? head_inc : head_r;
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
    tail_sum = {1'b0, head_r} + (AW+1)'(count_r);
    if (tail_sum >= (AW+1)'(DEPTH)) begin
      tail_sum = tail_sum - (AW+1)'(DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // keep the entry at the head registered, bypass a push into it
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wdata;
    end
    if (ctl.push && (tail == head_nxt)) begin
      rd_data_r <= wdata;
    end else begin
      rd_data_r <= mem[head_nxt];
    end
  end

  assign stat.full     = (count_r == CW'(DEPTH));
  assign stat.nonempty = (count_r != '0);
  assign head_data     = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/constant_bandwidth_server.sv -----
// An accepted item is held in the input register; its result is written to the result
// register on out_data when that is free or being taken. Throughput: one item per cycle
// unless out_ready stalls; the state update for an item is a single pass
// through the admission multiply and compare between the input and result registers.
// Reset: synchronous, active low; clears server state, queue pointers, valids and
// loads register defaults (full_budget 1, period_length 1, bandwidth_q16 65536).
`default_nettype none

module constant_bandwidth_server #(
  parameter int QUEUE_DEPTH = cbs_pkg::CBS_QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire cbs_pkg::cbs_in_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output cbs_pkg::cbs_out_t                        out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cbs_pkg::CBS_CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cbs_pkg::CBS_CFG_DATA_W-1:0]  cfg_data
);
  import cbs_pkg::*;

  localparam int LW = CBS_TIME_W + CBS_BW_W;

  logic [CBS_BUDGET_W-1:0] fbud_r;
  logic [CBS_PERIOD_W-1:0] period_r;
  logic [CBS_BW_W-1:0]     bw_r;

  logic                    in_v_r;
  cbs_in_t                 in_r;
  logic                    out_v_r;
  cbs_out_t                out_r;
  logic                    adv;
  logic                    fire;

  logic                    running_r,  running_nxt;
  logic [CBS_WORK_W-1:0]   cur_work_r, cur_work_nxt;
  logic [CBS_TIME_W-1:0]   job_dl_r,   job_dl_nxt;
  logic [CBS_TIME_W-1:0]   srv_dl_r,   srv_dl_nxt;
  logic [CBS_BUDGET_W-1:0] budget_r,   budget_nxt;

  logic [CBS_TIME_W-1:0]   period_ext;
  logic [CBS_TIME_W-1:0]   diff;
  logic [LW-1:0]           lhs;
  logic [LW-1:0]           rhs;
  logic                    admit;
  cbs_out_t                res;

  cbs_qctl_t               q_ctl;
  cbs_qstat_t              q_stat;
  logic [CBS_WORK_W-1:0]   q_head;

  cbs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (q_ctl),
    .wdata    (in_r.work_amount),
    .stat     (q_stat),
    .head_data(q_head)
  );

  assign cfg_ready = 1'b1;
  assign adv       = !out_v_r || out_ready;
  assign fire      = in_v_r && adv;
  assign in_ready  = !in_v_r || adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbud_r        <= CBS_BUDGET_W'(1);
      period_r      <= CBS_PERIOD_W'(1);
      bw_r          <= CBS_BW_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FULL_BUDGET:   fbud_r   <= cfg_data[CBS_BUDGET_W-1:0];
        CFG_PERIOD_LENGTH: period_r <= cfg_data[CBS_PERIOD_W-1:0];
        CFG_BANDWIDTH_Q16: bw_r     <= cfg_data[CBS_BW_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    period_ext = CBS_TIME_W'(period_r);
    diff       = srv_dl_r - in_r.arrival_time;
    lhs        = LW'({budget_r, 16'b0});
    rhs        = LW'(diff) * LW'(bw_r);
    admit      = (diff == '0) || diff[CBS_TIME_W-1] || (lhs >= rhs);

    running_nxt  = running_r;
    cur_work_nxt = cur_work_r;
    job_dl_nxt   = job_dl_r;
    srv_dl_nxt   = srv_dl_r;
    budget_nxt   = budget_r;
    q_ctl        = '0;
    res          = '0;

    if (fire) begin
      if (in_r.kind == KIND_ARRIVAL) begin
        if (!running_r) begin
          if (admit) begin
            srv_dl_nxt = in_r.arrival_time + period_ext;
            budget_nxt = fbud_r;
          end
          cur_work_nxt = in_r.work_amount;
          job_dl_nxt   = srv_dl_nxt;
          running_nxt  = 1'b1;
        end else if (q_stat.full) begin
          res.job_dropped = 1'b1;
        end else begin
          q_ctl.push = 1'b1;
        end
      end else if (!running_r) begin
        res.idle_tick = 1'b1;
      end else begin
        cur_work_nxt = (cur_work_r == '0) ? '0 : cur_work_r - 1'b1;
        budget_nxt   = (budget_r == '0) ? '0 : budget_r - 1'b1;
        if (cur_work_nxt == '0) begin
          res.job_finished = 1'b1;
          if (q_stat.nonempty) begin
            q_ctl.pop    = 1'b1;
            cur_work_nxt = q_head;
            job_dl_nxt   = srv_dl_r;
          end else begin
            running_nxt = 1'b0;
          end
        end
        // refill an exhausted budget and push the deadline out
        if (budget_nxt == '0) begin
          budget_nxt = fbud_r;
          srv_dl_nxt = srv_dl_r + period_ext;
          job_dl_nxt = srv_dl_nxt;
        end
      end
    end

    res.busy_res         = running_nxt;
    res.budget_now       = budget_nxt;
    res.deadline_now     = srv_dl_nxt;
    res.job_deadline_now = job_dl_nxt;
    res.work_left        = cur_work_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      running_r  <= 1'b0;
      cur_work_r <= '0;
      job_dl_r   <= '0;
      srv_dl_r   <= '0;
      budget_r   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      running_r  <= running_nxt;
      cur_work_r <= cur_work_nxt;
      job_dl_r   <= job_dl_nxt;
      srv_dl_r   <= srv_dl_nxt;
      budget_r   <= budget_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cbs_checker.sv -----
`default_nettype none

module cbs_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire cbs_pkg::cbs_out_t                   out_data
);
  import cbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_idle_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.idle_tick |-> !out_data.busy_res)
    else $error("idle tick reported while busy");

  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.job_dropped |-> out_data.busy_res)
    else $error("drop reported while idle");

  a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |-> out_data.work_left == '0)
    else $error("work left while idle");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.job_finished, out_data.job_dropped,
                              out_data.idle_tick}) <= 1)
    else $error("more than one flag set");

endmodule

bind constant_bandwidth_server cbs_checker u_cbs_checker (.*);

`default_nettype wire

// ----- sim/tb_constant_bandwidth_server.sv -----
`default_nettype none

module tb_constant_bandwidth_server;
  import cbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 240;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  cbs_in_t                   in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  cbs_out_t                  out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CBS_CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CBS_CFG_DATA_W-1:0] cfg_data = '0;

  constant_bandwidth_server u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  logic [CBS_BUDGET_W-1:0] cfg_full_budget = 16'd1;
  logic [CBS_PERIOD_W-1:0] cfg_period      = 24'd1;
  logic [CBS_BW_W-1:0]     cfg_bandwidth   = 17'h10000;

  logic                    srv_running  = 1'b0;
  logic [CBS_WORK_W-1:0]   job_work     = '0;
  logic [CBS_TIME_W-1:0]   job_deadline = '0;
  logic [CBS_TIME_W-1:0]   srv_deadline = '0;
  logic [CBS_BUDGET_W-1:0] budget_left  = '0;
  logic [CBS_WORK_W-1:0]   queued_work[$];

  cbs_out_t                predicted_status[$];
  logic [CBS_TIME_W-1:0]   work_clock = '0;
  int                      error_count = 0;
  int                      idle_cycles = 0;
  int                      tx_gap_pct = 30;
  int                      rx_stall_pct = 30;

  function automatic cbs_out_t advance_server(input cbs_in_t item);
    cbs_out_t r;
    logic [31:0] slack;
    logic [63:0] lhs;
    logic [63:0] rhs;
    r = '0;
    if (item.kind == KIND_ARRIVAL) begin
      if (!srv_running) begin
        slack = srv_deadline - item.arrival_time;
        lhs = {32'd0, budget_left, 16'd0};
        rhs = {32'd0, slack} * {47'd0, cfg_bandwidth};
        if (slack == 32'd0 || slack[31] || lhs >= rhs) begin
          srv_deadline = item.arrival_time + {8'd0, cfg_period};
          budget_left = cfg_full_budget;
        end
        job_work = item.work_amount;
        job_deadline = srv_deadline;
        srv_running = 1'b1;
      end else if (queued_work.size() >= CBS_QUEUE_DEPTH) begin
        r.job_dropped = 1'b1;
      end else begin
        queued_work.push_back(item.work_amount);
      end
    end else if (!srv_running) begin
      r.idle_tick = 1'b1;
    end else begin
      if (job_work != 0) job_work--;
      if (budget_left != 0) budget_left--;
      if (job_work == 0) begin
        if (queued_work.size() != 0) begin
          job_work = queued_work.pop_front();
          job_deadline = srv_deadline;
        end else begin
          srv_running = 1'b0;
        end
        r.job_finished = 1'b1;
      end
      if (budget_left == 0) begin
        budget_left = cfg_full_budget;
        srv_deadline = srv_deadline + {8'd0, cfg_period};
        job_deadline = srv_deadline;
      end
    end
    r.busy_res = srv_running;
    r.budget_now = budget_left;
    r.deadline_now = srv_deadline;
    r.job_deadline_now = job_deadline;
    r.work_left = job_work;
    return r;
  endfunction

  function automatic cbs_in_t make_item(input logic kind, input logic [31:0] at,
                                        input logic [15:0] work);
    cbs_in_t it;
    it.kind = kind;
    it.arrival_time = at;
    it.work_amount = work;
    return it;
  endfunction

  function automatic cbs_in_t tick_item();
    return make_item(KIND_TICK, $urandom, 16'($urandom));
  endfunction

  function automatic cbs_in_t pick_item(input int arrival_pct, input int work_max);
    cbs_in_t it;
    int sel;
    it = tick_item();
    if ($urandom_range(0, 99) < arrival_pct) begin
      it.kind = KIND_ARRIVAL;
      sel = $urandom_range(0, 19);
      if (sel < 8) it.arrival_time = work_clock + $urandom_range(0, 3);
      else if (sel < 14) it.arrival_time = srv_deadline - $urandom_range(0, 64);
      else if (sel < 17) it.arrival_time = srv_deadline + $urandom_range(0, 2);
      if (!srv_running || queued_work.size() < CBS_QUEUE_DEPTH)
        it.work_amount = ($urandom_range(0, 19) == 0) ? 16'd0 :
                         16'($urandom_range(1, work_max));
    end
    return it;
  endfunction

  task automatic send_item(input cbs_in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predicted_status.push_back(advance_server(item));
    if (item.kind == KIND_TICK) work_clock++;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_server(input logic [23:0] budget_val, input logic [23:0] period_val,
                                input logic [23:0] bw_val);
    cbs_cfg_idx_t regs[3] = '{CFG_FULL_BUDGET, CFG_PERIOD_LENGTH, CFG_BANDWIDTH_Q16};
    logic [23:0] vals[3];
    vals = '{budget_val, period_val, bw_val};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        CFG_FULL_BUDGET:   cfg_full_budget = vals[i][CBS_BUDGET_W-1:0];
        CFG_PERIOD_LENGTH: cfg_period = vals[i][CBS_PERIOD_W-1:0];
        CFG_BANDWIDTH_Q16: cfg_bandwidth = vals[i][CBS_BW_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic tick_until_idle();
    while (srv_running) send_item(tick_item());
  endtask

  task automatic test_idle_and_admission();
    send_item(tick_item());
    send_item(make_item(KIND_ARRIVAL, 32'd0, 16'd0));
    send_item(tick_item());
    send_item(make_item(KIND_ARRIVAL, 32'd0, 16'd2));
    send_item(make_item(KIND_ARRIVAL, 32'd7, 16'd1));
    repeat (3) send_item(tick_item());
    send_item(make_item(KIND_ARRIVAL, 32'd100, 16'd1));
    send_item(tick_item());
  endtask

  task automatic test_register_extremes();
    tick_until_idle();
    wait_for_results();
    program_server(24'd0, 24'd0, 24'd0);
    send_item(make_item(KIND_ARRIVAL, 32'hFFFF_FFFF, 16'd2));
    repeat (3) send_item(tick_item());
    wait_for_results();
    program_server(24'h00FFFF, 24'hFFFFFF, 24'h01FFFF);
    send_item(make_item(KIND_ARRIVAL, 32'hFFFF_FFF0, 16'd1));
    send_item(tick_item());
    send_item(make_item(KIND_ARRIVAL, 32'h00FF_0000, 16'd1));
    send_item(tick_item());
    send_item(make_item(KIND_ARRIVAL, 32'h8000_0000, 16'd1));
    send_item(tick_item());
  endtask

  task automatic test_queue_overflow();
    tick_until_idle();
    wait_for_results();
    program_server(24'd4, 24'd16, 24'd32768);
    send_item(make_item(KIND_ARRIVAL, work_clock, 16'd3));
    send_item(make_item(KIND_ARRIVAL, work_clock, 16'd0));
    repeat (CBS_QUEUE_DEPTH - 1)
      send_item(make_item(KIND_ARRIVAL, $urandom, 16'($urandom_range(1, 3))));
    send_item(make_item(KIND_ARRIVAL, 32'd0, 16'hFFFF));
    send_item(make_item(KIND_ARRIVAL, 32'hFFFF_FFFF, 16'h0001));
    tick_until_idle();
  endtask

  task automatic test_random_traffic();
    logic [23:0] budget_val;
    logic [23:0] period_val;
    logic [23:0] bw_val;
    int arrival_pct;
    int work_max;
    for (int phase = 0; phase < 8; phase++) begin
      wait_for_results();
      tx_gap_pct = 30;
      rx_stall_pct = 30;
      case (phase)
        0: begin
          budget_val = 24'($urandom_range(1, 4)); period_val = 24'($urandom_range(1, 8));
          bw_val = 24'h10000; arrival_pct = 40; work_max = 4;
        end
        1: begin
          budget_val = 24'($urandom_range(1, 16)); period_val = 24'($urandom_range(4, 32));
          bw_val = 24'($urandom_range(0, 65536)); arrival_pct = 70; work_max = 6;
        end
        2: begin
          budget_val = 24'h00FFFF; period_val = 24'hFFFFFF;
          bw_val = 24'h01FFFF; arrival_pct = 50; work_max = 3;
        end
        3: begin
          budget_val = 24'($urandom_range(1, 8)); period_val = 24'($urandom_range(1, 16));
          bw_val = 24'($urandom_range(0, 24'h01FFFF)); arrival_pct = 35; work_max = 8;
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
        4: begin
          budget_val = 24'd0; period_val = 24'd0;
          bw_val = 24'd0; arrival_pct = 45; work_max = 3;
        end
        5: begin
          budget_val = 24'($urandom_range(1, 100)); period_val = 24'($urandom_range(1, 200));
          bw_val = 24'($urandom_range(16384, 65536)); arrival_pct = 60; work_max = 12;
        end
        6: begin
          budget_val = {8'd0, 16'($urandom)}; period_val = 24'($urandom);
          bw_val = 24'($urandom_range(0, 24'h01FFFF)); arrival_pct = 40; work_max = 5;
        end
        default: begin
          budget_val = 24'($urandom_range(2, 6)); period_val = 24'($urandom_range(2, 10));
          bw_val = 24'h10000; arrival_pct = 80; work_max = 2;
        end
      endcase
      program_server(budget_val, period_val, bw_val);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == PHASE_ITEMS / 2) wait_for_results();
        send_item(pick_item(arrival_pct, work_max));
      end
    end
    tx_gap_pct = 30;
    rx_stall_pct = 30;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cbs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_status.size() == 0) begin
        $error("result item 0x%0h with nothing expected", out_data);
        error_count++;
      end else begin
        want = predicted_status.pop_front();
        check_field("job_finished", 32'(want.job_finished), 32'(out_data.job_finished));
        check_field("job_dropped", 32'(want.job_dropped), 32'(out_data.job_dropped));
        check_field("idle_tick", 32'(want.idle_tick), 32'(out_data.idle_tick));
        check_field("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
        check_field("budget_now", 32'(want.budget_now), 32'(out_data.budget_now));
        check_field("deadline_now", want.deadline_now, out_data.deadline_now);
        check_field("job_deadline_now", want.job_deadline_now, out_data.job_deadline_now);
        check_field("work_left", 32'(want.work_left), 32'(out_data.work_left));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_and_admission();
    test_register_extremes();
    test_queue_overflow();
    test_random_traffic();
    wait_for_results();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
